/* design/sspu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo status parser package
// Shared widths, constants and the result record of the status frame parser.
// ----------------------------------------------------------------------------
package sspu_pkg;

    localparam int unsigned MOTOR_COUNT_DEF = 5;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [3:0] LEN_VOLT  = 4'd3;
    localparam logic [3:0] LEN_SHORT = 4'd8;
    localparam logic [3:0] LEN_LONG  = 4'd11;

    localparam logic KIND_FEEDBACK = 1'b0;
    localparam logic KIND_VOLTAGE  = 1'b1;

    // Depth of the body byte history feeding the result taps
    localparam int unsigned HIST_DEPTH = 6;

    // One decoded status frame
    typedef struct packed {
        logic        frame_kind;
        logic [7:0]  servo_id;
        logic [15:0] position;
        logic [15:0] speed;
        logic [15:0] torque;
        logic [7:0]  voltage_tenths;
    } result_t;

    // Handshake between the input register and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_beat_t;

endpackage

/* design/sspu_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module sspu_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 take,
    output sspu_pkg::byte_beat_t held
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // Room when empty or when the held beat leaves this cycle
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= in_data;
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

/* design/sspu_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status frame parser
// Header hunt, id/length capture, running checksum and body byte history.
// Produces the decoded result for the byte it consumes in the same cycle.
// ----------------------------------------------------------------------------
module sspu_parser
#(
    parameter int unsigned MOTOR_COUNT = sspu_pkg::MOTOR_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output sspu_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4
    } phase_t;

    localparam logic [7:0] ID_MAX = 8'(MOTOR_COUNT);

    phase_t     phase_reg,  phase_next;
    logic [7:0] id_reg,     id_next;
    logic [3:0] len_reg,    len_next;
    logic [3:0] taken_reg,  taken_next;
    logic [7:0] sum_reg,    sum_next;
    logic [7:0] hist_reg [sspu_pkg::HIST_DEPTH];

    logic [3:0] taken_inc;
    logic       last_byte;
    logic       sum_ok;
    logic       id_ok;

    assign taken_inc = taken_reg + 4'd1;
    assign last_byte = (taken_inc >= len_reg);
    assign sum_ok    = (~sum_reg == rx_byte);
    assign id_ok     = (id_reg != 8'd0) && (id_reg <= ID_MAX);

    // Next state of the frame tracker
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == sspu_pkg::HDR_BYTE)
                    phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                phase_next = (rx_byte == sspu_pkg::HDR_BYTE) ? PH_ID : PH_HUNT;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                sum_next   = rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (rx_byte == {4'd0, sspu_pkg::LEN_VOLT} ||
                    rx_byte == {4'd0, sspu_pkg::LEN_SHORT} ||
                    rx_byte == {4'd0, sspu_pkg::LEN_LONG})
                begin
                    len_next   = rx_byte[3:0];
                    taken_next = 4'd0;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                taken_next = taken_inc;
                if (last_byte)
                begin
                    sum_next   = 8'd0;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    sum_next = sum_reg + rx_byte;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            id_reg    <= 8'd0;
            len_reg   <= 4'd0;
            taken_reg <= 4'd0;
            sum_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

    // Body byte history, newest in entry 0
    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_BODY)
        begin
            hist_reg[0] <= rx_byte;
            for (int i = 1; i < sspu_pkg::HIST_DEPTH; i++)
                hist_reg[i] <= hist_reg[i - 1];
        end
    end

    // Result on the checksum byte; fields sit just before it in the body
    always_comb
    begin
        res = '0;
        res_valid = 1'b0;
        res.servo_id = id_reg;
        if (phase_reg == PH_BODY && last_byte && sum_ok)
        begin
            if (len_reg == sspu_pkg::LEN_VOLT)
            begin
                res_valid            = 1'b1;
                res.frame_kind       = sspu_pkg::KIND_VOLTAGE;
                res.voltage_tenths   = hist_reg[0];
            end
            else
            begin
                res_valid      = id_ok;
                res.frame_kind = sspu_pkg::KIND_FEEDBACK;
                res.position   = {hist_reg[5], hist_reg[4]};
                res.speed      = {hist_reg[3], hist_reg[2]};
                res.torque     = {hist_reg[1], hist_reg[0]};
            end
        end
    end

endmodule

/* design/sspu_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded frame until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module sspu_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              load_valid,
    input  sspu_pkg::result_t load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              free,
    output sspu_pkg::result_t out_data
);

    logic              valid_reg;
    logic              valid_next;
    sspu_pkg::result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = load_valid;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/servo_status_frame_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo status frame parser
// Takes received bus bytes, tracks header/id/length/body, verifies the
// checksum and emits one decoded feedback or voltage beat per good frame.
// ----------------------------------------------------------------------------
// The checksum byte passes the input register and then the result register
// before its result beat. Throughput: 1 byte per cycle while the result register is free,
// set by the parser step between the input register and the result register.
// Reset: rst_n clears the frame tracker and both valid flags; no clear pass.
module servo_status_frame_parser_unit
#(
    parameter int unsigned MOTOR_COUNT = sspu_pkg::MOTOR_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] servo_id, [23:8] position,
                                        // [39:24] speed, [55:40] torque,
                                        // [63:56] voltage_tenths
    output logic        m_axis_tuser    // [0] frame_kind
);

    sspu_pkg::byte_beat_t held;
    sspu_pkg::result_t    res;
    sspu_pkg::result_t    out_data;
    logic                 res_valid;
    logic                 out_free;
    logic                 step;

    // Parser advances when a byte is held and the result slot can take it
    assign step = held.valid && out_free;

    sspu_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .take     (step),
        .held     (held)
    );

    sspu_parser
    #(
        .MOTOR_COUNT (MOTOR_COUNT)
    )
    u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (held.data),
        .res_valid (res_valid),
        .res       (res)
    );

    sspu_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (res_valid),
        .load_data  (res),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .free       (out_free),
        .out_data   (out_data)
    );

    assign m_axis_tuser = out_data.frame_kind;
    assign m_axis_tdata = {out_data.voltage_tenths, out_data.torque, out_data.speed,
                           out_data.position, out_data.servo_id};

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo status frame parser testbench
// Streams bus bytes into the parser: short directed frames first, then mostly
// well-formed random frames mixed with noise, broken headers, bad lengths and
// bad checksums. A byte-level frame decoder in the scoreboard predicts every
// decoded feedback and voltage beat, and each output beat is compared field by
// field. Sender and receiver stall at random with several idle mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MOTORS = sspu_pkg::MOTOR_COUNT_DEF;

    typedef enum logic [2:0] {PH_HUNT, PH_HDR2, PH_ID, PH_LEN, PH_BODY} parse_phase_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} body_fill_t;

    // Frame decoder and result queue
    class status_frame_board;
        sspu_pkg::result_t frames_due[$];
        parse_phase_t      phase;
        logic [7:0]        frame_id;
        logic [3:0]        frame_len;
        logic [3:0]        taken;
        logic [7:0]        sum;
        logic [7:0]        body[16];
        int unsigned       motor_count;
        int unsigned       fails;
        int unsigned       feedback_seen;
        int unsigned       voltage_seen;

        function new(int unsigned motors);
            motor_count   = motors;
            phase         = PH_HUNT;
            frame_id      = '0;
            frame_len     = '0;
            taken         = '0;
            sum           = '0;
            fails         = 0;
            feedback_seen = 0;
            voltage_seen  = 0;
            foreach (body[i]) body[i] = '0;
        endfunction

        // Checksum and field extraction once the last body byte is in
        function void close_frame();
            sspu_pkg::result_t r;
            logic [3:0]        base;
            if (~sum != body[frame_len - 4'd1])
                return;
            r = '0;
            r.servo_id = frame_id;
            if (frame_len == sspu_pkg::LEN_VOLT) begin
                r.frame_kind     = sspu_pkg::KIND_VOLTAGE;
                r.voltage_tenths = body[1];
                frames_due.push_back(r);
                return;
            end
            if (frame_id == 8'd0 || frame_id > motor_count)
                return;
            base         = frame_len - 4'd7;
            r.frame_kind = sspu_pkg::KIND_FEEDBACK;
            r.position   = {body[base],        body[base + 4'd1]};
            r.speed      = {body[base + 4'd2], body[base + 4'd3]};
            r.torque     = {body[base + 4'd4], body[base + 4'd5]};
            frames_due.push_back(r);
        endfunction

        // One accepted input beat
        function void note_byte(logic [7:0] b);
            case (phase)
                PH_HUNT: if (b == sspu_pkg::HDR_BYTE) phase = PH_HDR2;
                PH_HDR2: phase = (b == sspu_pkg::HDR_BYTE) ? PH_ID : PH_HUNT;
                PH_ID:
                begin
                    frame_id = b;
                    sum      = b;
                    phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    if (b == {4'd0, sspu_pkg::LEN_VOLT} || b == {4'd0, sspu_pkg::LEN_SHORT} ||
                        b == {4'd0, sspu_pkg::LEN_LONG})
                    begin
                        frame_len = b[3:0];
                        taken     = '0;
                        sum       = sum + b;
                        phase     = PH_BODY;
                    end
                    else
                    begin
                        phase = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    body[taken] = b;
                    taken       = taken + 4'd1;
                    if (taken >= frame_len)
                    begin
                        close_frame();
                        sum   = '0;
                        phase = PH_HUNT;
                    end
                    else
                    begin
                        sum = sum + b;
                    end
                end
                default: phase = PH_HUNT;
            endcase
        endfunction

        // One accepted output beat
        function void check_result(sspu_pkg::result_t got);
            sspu_pkg::result_t want;
            if (frames_due.size() == 0)
            begin
                $error("decoded beat with no frame pending: kind %0d id %0d",
                       got.frame_kind, got.servo_id);
                fails++;
                return;
            end
            want = frames_due.pop_front();
            if (want.frame_kind == sspu_pkg::KIND_VOLTAGE) voltage_seen++;
            else feedback_seen++;
            if (got.frame_kind != want.frame_kind)
            begin
                $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
                fails++;
            end
            if (got.servo_id != want.servo_id)
            begin
                $error("servo_id: expected %0d, got %0d", want.servo_id, got.servo_id);
                fails++;
            end
            if (got.position != want.position)
            begin
                $error("position: expected %h, got %h", want.position, got.position);
                fails++;
            end
            if (got.speed != want.speed)
            begin
                $error("speed: expected %h, got %h", want.speed, got.speed);
                fails++;
            end
            if (got.torque != want.torque)
            begin
                $error("torque: expected %h, got %h", want.torque, got.torque);
                fails++;
            end
            if (got.voltage_tenths != want.voltage_tenths)
            begin
                $error("voltage_tenths: expected %0d, got %0d",
                       want.voltage_tenths, got.voltage_tenths);
                fails++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    int unsigned src_idle_pct  = 20;
    int unsigned sink_idle_pct = 49;
    int unsigned bytes_sent    = 0;

    status_frame_board board = new(MOTORS);

    servo_status_frame_parser_unit #(.MOTOR_COUNT(MOTORS)) u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output side: check accepted beats, then pick next ready
    always @(posedge clk)
    begin
        sspu_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame_kind     = m_axis_tuser;
            got.servo_id       = m_axis_tdata[7:0];
            got.position       = m_axis_tdata[23:8];
            got.speed          = m_axis_tdata[39:24];
            got.torque         = m_axis_tdata[55:40];
            got.voltage_tenths = m_axis_tdata[63:56];
            board.check_result(got);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Drive one byte beat, with an optional random gap before it
    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        board.note_byte(b);
        bytes_sent++;
    endtask

    // Header, id, length, body and checksum; bad_sum spoils the checksum
    task automatic push_frame(input logic [7:0] id, input logic [3:0] len,
                              input body_fill_t fill, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        push_byte(sspu_pkg::HDR_BYTE);
        push_byte(sspu_pkg::HDR_BYTE);
        push_byte(id);
        push_byte({4'd0, len});
        sum = id + {4'd0, len};
        for (i = 0; i < int'(len) - 1; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            sum = sum + b;
            push_byte(b);
        end
        b = ~sum;
        if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
        push_byte(b);
    endtask

    // Random mix: mostly clean frames, some noise and broken sequences
    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        logic [3:0]  len;
        logic [7:0]  id;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                case ($urandom_range(0, 2))
                    0:       len = sspu_pkg::LEN_VOLT;
                    1:       len = sspu_pkg::LEN_SHORT;
                    default: len = sspu_pkg::LEN_LONG;
                endcase
                if ($urandom_range(0, 99) < 80) id = 8'($urandom_range(1, MOTORS));
                else id = 8'($urandom_range(0, 255));
                push_frame(id, len, FILL_RANDOM, $urandom_range(0, 99) < 10);
            end
            else if (pick < 80)
            begin
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 86)
            begin
                // broken second header byte
                push_byte(sspu_pkg::HDR_BYTE);
                push_byte(8'($urandom_range(0, 254)));
            end
            else if (pick < 93)
            begin
                // header and id, then a random length byte, usually not an accepted length
                push_byte(sspu_pkg::HDR_BYTE);
                push_byte(sspu_pkg::HDR_BYTE);
                push_byte(8'($urandom_range(0, 255)));
                len = 4'($urandom_range(0, 15));
                push_byte({4'($urandom_range(0, 15)), len});
            end
            else
            begin
                // stray 0xFF ahead of a frame shifts the id
                push_byte(sspu_pkg::HDR_BYTE);
                push_frame(8'($urandom_range(1, MOTORS)), sspu_pkg::LEN_LONG,
                           FILL_RANDOM, 1'b0);
            end
        end
    endtask

    initial
    begin
        int unsigned waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        push_frame(8'd1,            sspu_pkg::LEN_VOLT,  FILL_ZERO,   1'b0);
        push_frame(8'hFF,           sspu_pkg::LEN_VOLT,  FILL_ONES,   1'b0);
        push_frame(8'd1,            sspu_pkg::LEN_SHORT, FILL_ONES,   1'b0);
        push_frame(8'(MOTORS),      sspu_pkg::LEN_LONG,  FILL_ZERO,   1'b0);
        push_frame(8'(MOTORS),      sspu_pkg::LEN_LONG,  FILL_RANDOM, 1'b0);
        push_frame(8'd0,            sspu_pkg::LEN_SHORT, FILL_RANDOM, 1'b0);
        push_frame(8'(MOTORS + 1),  sspu_pkg::LEN_SHORT, FILL_RANDOM, 1'b0);
        push_frame(8'd2,            sspu_pkg::LEN_VOLT,  FILL_RANDOM, 1'b1);
        push_frame(8'd3,            sspu_pkg::LEN_LONG,  FILL_RANDOM, 1'b1);
        push_byte(sspu_pkg::HDR_BYTE);
        push_byte(8'h00);
        push_byte(sspu_pkg::HDR_BYTE);
        push_byte(sspu_pkg::HDR_BYTE);
        push_byte(8'd2);
        push_byte(8'h13);
        push_byte(sspu_pkg::HDR_BYTE);
        push_frame(8'd4, sspu_pkg::LEN_SHORT, FILL_RANDOM, 1'b0);
        push_frame(8'd4, sspu_pkg::LEN_SHORT, FILL_RANDOM, 1'b0);

        // Random traffic under three idle mixes
        random_traffic(140);
        src_idle_pct  = 49;
        sink_idle_pct = 20;
        random_traffic(140);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_traffic(140);
        s_axis_tvalid <= 1'b0;

        // Drain, then wait for any stray beat
        waited = 0;
        while (board.frames_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (board.frames_due.size() != 0)
        begin
            $error("%0d decoded frames never came out", board.frames_due.size());
            board.fails++;
        end

        $display("Sent %0d bus bytes under three stall mixes;", bytes_sent);
        $display("checked %0d feedback and %0d voltage beats.",
                 board.feedback_seen, board.voltage_seen);
        if (board.fails == 0)
            $display("PASS servo_status_frame_parser_unit");
        else
            $display("FAIL servo_status_frame_parser_unit");
        $finish;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("FAIL servo_status_frame_parser_unit");
        $finish;
    end

endmodule
